[hw/rtl/fic_pkg.sv]
`default_nettype none
package fic_pkg;
    localparam logic [1:0] TYPE_FP32  = 2'd0;
    localparam logic [1:0] TYPE_INT8  = 2'd1;
    localparam logic [1:0] TYPE_INT32 = 2'd2;
    localparam logic [1:0] TYPE_NONE  = 2'd3;

    localparam logic [0:0] CFG_SOURCE = 1'b0;
    localparam logic [0:0] CFG_TARGET = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef struct packed {
        logic [31:0] bits;
        logic        status;
    } t_result;
endpackage
`default_nettype wire

[hw/rtl/fic_convert.sv]
`default_nettype none
module fic_convert
    import fic_pkg::*;
(
    input  wire logic [1:0]  i_source_type,
    input  wire logic [1:0]  i_target_type,
    input  wire logic [31:0] i_source_bits,
    output t_result          o_result
);
    logic [7:0]  f_ex;
    logic [22:0] f_man;
    logic        f_neg;
    logic [4:0]  f_e;
    logic [31:0] f_mag;
    logic [31:0] f_int;
    logic        f_nan;
    logic        f_small;
    logic        f_sat;
    logic [31:0] s_val;
    logic [31:0] i_mag;
    logic [4:0]  i_p;
    logic [31:0] i_norm;
    logic [23:0] i_keep;
    logic [24:0] i_keep_r;
    logic        i_g;
    logic        i_st;
    logic [7:0]  i_exp;
    logic [31:0] i_fp;
    logic [7:0]  clamp8;
    logic        neg_in;

    always_comb begin
        f_ex    = i_source_bits[30:23];
        f_man   = i_source_bits[22:0];
        f_neg   = i_source_bits[31];
        f_nan   = (f_ex == 8'hFF) && (f_man != 23'd0);
        f_small = f_ex < 8'd127;
        f_e     = f_ex[4:0] - 5'd31;
        f_sat   = !f_small && (f_ex >= 8'd158);
        if (f_e >= 5'd23)
            f_mag = {8'd0, 1'b1, f_man} << (f_e - 5'd23);
        else
            f_mag = {8'd0, 1'b1, f_man} >> (5'd23 - f_e);
        if (f_nan || f_small)
            f_int = 32'd0;
        else if (f_sat)
            f_int = f_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            f_int = f_neg ? (32'd0 - f_mag) : f_mag;

        if (i_source_type == TYPE_FP32)
            s_val = f_int;
        else if (i_source_type == TYPE_INT8)
            s_val = {{24{i_source_bits[7]}}, i_source_bits[7:0]};
        else
            s_val = i_source_bits;

        neg_in = s_val[31];
        if (neg_in && (s_val[31:7] != '1))
            clamp8 = 8'h80;
        else if (!neg_in && (s_val[31:7] != '0))
            clamp8 = 8'h7F;
        else
            clamp8 = s_val[7:0];

        i_mag = neg_in ? (32'd0 - s_val) : s_val;
        i_p   = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (i_mag[k]) i_p = 5'(k);
        end
        i_norm   = i_mag << (5'd31 - i_p);
        i_keep   = i_norm[31:8];
        i_g      = i_norm[7];
        i_st     = i_norm[6:0] != 7'd0;
        i_keep_r = {1'b0, i_keep} + 25'(i_g && (i_st || i_keep[0]));
        i_exp    = 8'd127 + {3'd0, i_p} + {7'd0, i_keep_r[24]};
        if (i_mag == 32'd0)
            i_fp = 32'd0;
        else
            i_fp = {neg_in, i_exp,
                    i_keep_r[24] ? i_keep_r[23:1] : i_keep_r[22:0]};

        o_result.status = STATUS_OK;
        o_result.bits   = 32'd0;
        if ((i_source_type == i_target_type) || (i_source_type == TYPE_NONE)
            || (i_target_type == TYPE_NONE)) begin
            o_result.status = STATUS_ERROR;
        end else if (i_target_type == TYPE_INT8) begin
            o_result.bits = {24'd0, clamp8};
        end else if (i_target_type == TYPE_FP32) begin
            o_result.bits = i_fp;
        end else begin
            o_result.bits = s_val;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/fp32_int8_int32_converter_unit.sv]
// Element converter between fp32, int8 and int32.
// Configuration: write i_cfg_we with i_cfg_index 0 (source type) or 1
// (target type) and the type code in i_cfg_data: 0 fp32, 1 int8, 2 int32.
// Write only while no transfer is in flight.
// Input channel: i_valid / o_stall with i_source_bits; a transfer happens
// when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_converted_bits and o_status;
// status 1 flags equal or unsupported types with a zero result.
// o_valid rises in the cycle after an input transfer. Throughput: one
// element per cycle while the output is not stalled, set by the single result register.
// A stalled result holds; o_stall rises only while a held result is
// stalled, so a new element enters in the same cycle the old one leaves.
// Reset: output empty, source type fp32, target type int32.
`default_nettype none
module fp32_int8_int32_converter_unit
    import fic_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_source_bits,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_converted_bits,
    output logic             o_status
);
    logic [1:0] r_source_type;
    logic [1:0] r_target_type;
    logic       r_valid;
    t_result    r_result;
    t_result    n_result;

    fic_convert u_convert (
        .i_source_type(r_source_type),
        .i_target_type(r_target_type),
        .i_source_bits(i_source_bits),
        .o_result     (n_result)
    );

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_type <= TYPE_FP32;
            r_target_type <= TYPE_INT32;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SOURCE) r_source_type <= i_cfg_data;
                else r_target_type <= i_cfg_data;
            end
            if (!o_stall) r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) r_result <= n_result;
    end

    assign o_valid          = r_valid;
    assign o_converted_bits = r_result.bits;
    assign o_status         = r_result.status;
endmodule
`default_nettype wire

[tb/fic_checker.sv]
`default_nettype none
module fic_checker
    import fic_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic        i_stall_in,
    input  wire logic [31:0] i_source_bits,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] i_converted_bits,
    input  wire logic        i_status,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0] src_type;
    logic [1:0] dst_type;
    t_result    conv_q[$];

    assign o_pending = conv_q.size();

    function automatic logic signed [63:0] float_to_int(input logic [31:0] b);
        logic [7:0]  ex;
        logic [22:0] man;
        int          e;
        logic [63:0] mag;
        ex  = b[30:23];
        man = b[22:0];
        if (ex == 8'hFF && man != 0) return 0;
        if (ex < 8'd127) return 0;
        e = int'(ex) - 127;
        if (e >= 31) return b[31] ? -64'sd2147483648 : 64'sd2147483647;
        mag = {40'd0, 1'b1, man};
        if (e >= 23) mag = mag << (e - 23);
        else mag = mag >> (23 - e);
        return b[31] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [31:0] int_to_float(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        int          p;
        int          sh;
        mag = v < 0 ? -v : v;
        if (mag == 0) return 32'd0;
        p = 0;
        while (p < 63 && (mag >> (p + 1)) != 0) p++;
        if (p <= 23) begin
            keep = mag << (23 - p);
        end else begin
            sh   = p - 23;
            rem  = mag & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            keep = mag >> sh;
            if (rem > half || (rem == half && keep[0])) begin
                keep++;
                if (keep == (64'd1 << 24)) begin
                    keep = keep >> 1;
                    p++;
                end
            end
        end
        return {v < 0, 8'(p + 127), keep[22:0]};
    endfunction

    function automatic logic signed [63:0] clamp_byte(input logic signed [63:0] v);
        if (v < -128) return -128;
        if (v > 127) return 127;
        return v;
    endfunction

    function automatic t_result convert(input logic [31:0] b);
        t_result          r;
        logic signed [63:0] v;
        r.bits   = 32'd0;
        r.status = STATUS_OK;
        if (src_type == dst_type || src_type == TYPE_NONE || dst_type == TYPE_NONE) begin
            r.status = STATUS_ERROR;
            return r;
        end
        if (src_type == TYPE_FP32) begin
            v = float_to_int(b);
            if (dst_type == TYPE_INT8) v = clamp_byte(v);
            r.bits = v[31:0];
        end else begin
            if (src_type == TYPE_INT8) v = 64'($signed(b[7:0]));
            else v = 64'($signed(b));
            if (dst_type == TYPE_FP32) r.bits = int_to_float(v);
            else if (dst_type == TYPE_INT8) r.bits = 32'(clamp_byte(v)) ;
            else r.bits = v[31:0];
        end
        if (dst_type == TYPE_INT8) r.bits = {24'd0, r.bits[7:0]};
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            src_type <= TYPE_FP32;
            dst_type <= TYPE_INT32;
            conv_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (conv_q.size() == 0) begin
                    report("unexpected transfer", i_converted_bits, 32'd0);
                end else begin
                    want = conv_q.pop_front();
                    if (i_converted_bits !== want.bits)
                        report("converted_bits", i_converted_bits, want.bits);
                    if (i_status !== want.status)
                        report("status", 32'(i_status), 32'(want.status));
                end
            end
            if (i_valid && !i_stall_in) conv_q.push_back(convert(i_source_bits));
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SOURCE) src_type <= i_cfg_data;
                else dst_type <= i_cfg_data;
            end
        end
    end
endmodule
`default_nettype wire

[tb/fp32_int8_int32_converter_unit_tb.sv]
`default_nettype none
module fp32_int8_int32_converter_unit_tb
    import fic_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [1:0]  cfg_data = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] source_bits = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] converted_bits;
    logic        status;
    int          errors;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;
    int          quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    fp32_int8_int32_converter_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall), .i_source_bits(source_bits),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_converted_bits(converted_bits), .o_status(status)
    );

    fic_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_source_bits(source_bits),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_converted_bits(converted_bits), .i_status(status),
        .o_errors(errors), .o_pending(pending)
    );

    // hold off the output side for a counted stretch, else stall at random
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall   <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[fp32_int8_int32_converter_unit] ERROR");
            $finish;
        end
    end

    task automatic send(input logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid    <= 1'b1;
        source_bits <= b;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_type(input logic idx, input logic [1:0] code);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= code;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_types(input logic [1:0] s, input logic [1:0] t);
        drain();
        write_type(CFG_SOURCE, s);
        write_type(CFG_TARGET, t);
    endtask

    function automatic logic [31:0] random_element();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(7))
            0: r = {r[31], 8'hFF, r[22:0]};
            1: r = {r[31], 8'(126 + $urandom_range(8)), r[22:0]};
            2: r = {r[31], 8'(140 + $urandom_range(20)), r[22:0]};
            3: r = 32'($signed(8'(r)));
            4: r = {r[31], 8'(150 + $urandom_range(12)), 23'd0} | (r & 32'h3);
            default: ;
        endcase
        return r;
    endfunction

    logic [31:0] corner[] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h4300_0000, 32'hC300_0000, 32'h42FE_0000, 32'hC301_0000, 32'h4F00_0000,
        32'hCF00_0000, 32'h3F7F_FFFF, 32'h0000_007F, 32'h0000_0080, 32'hFFFF_FF80,
        32'h0100_0001, 32'h0100_0003, 32'h8000_0001, 32'h1234_5681, 32'h0000_00FF};

    initial begin
        logic [1:0] s;
        logic [1:0] t;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int st = 0; st < 4; st++) begin
            for (int tt = 0; tt < 4; tt++) begin
                set_types(2'(st), 2'(tt));
                foreach (corner[k]) if (st < 3 && tt < 3 && st != tt || k < 2) send(corner[k]);
            end
        end
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 27 : phase == 1 ? 51 : 0;
            recv_idle_pct = phase == 0 ? 51 : phase == 1 ? 27 : 0;
            for (int blk = 0; blk < 12; blk++) begin
                s = 2'($urandom_range(2));
                t = 2'($urandom_range(2));
                if ($urandom_range(9) == 0) t = 2'($urandom_range(3));
                set_types(s, t);
                if (blk == 3) hold_cycles = 40;
                repeat (20) send(random_element());
            end
        end
        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("[fp32_int8_int32_converter_unit] OK");
        else $display("[fp32_int8_int32_converter_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

[fp32_int8_int32_converter_unit.f]
hw/rtl/fic_pkg.sv
hw/rtl/fic_convert.sv
hw/rtl/fp32_int8_int32_converter_unit.sv
tb/fic_checker.sv
tb/fp32_int8_int32_converter_unit_tb.sv
